// File: sv/i2a_pkg.sv
// shared types, codes and constants of the integer to ascii formatter
package i2a_pkg;

  localparam int IN_VALUE_W     = 32;
  localparam int HEX_DIGITS_DEF = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_X     = 8'h78;

  typedef struct packed {
    logic [1:0]            func;
    logic [IN_VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_word_t;

  // classification carried with each queued job
  typedef struct packed {
    logic hex;
    logic neg;
  } job_ctl_t;

  // status of the job queue seen by the front and the back
  typedef struct packed {
    logic ready;
    logic valid;
  } q_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'ha: ch = 8'h41;
      4'hb: ch = 8'h42;
      4'hc: ch = 8'h43;
      4'hd: ch = 8'h44;
      4'he: ch = 8'h45;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

endpackage

// File: sv/i2a_front.sv
// front stage: accepts words, masks the value, forms sign and magnitude
module i2a_front #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  i2a_pkg::in_word_t       in_data,
  input  i2a_pkg::q_status_t      q_status,
  output logic                    push,
  output i2a_pkg::job_ctl_t       job_ctl,
  output logic [VALUE_BITS-1:0]   job_mag
);
  import i2a_pkg::*;

  logic                  front_valid_r, front_valid_nxt;
  job_ctl_t              ctl_r, ctl_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [VALUE_BITS-1:0] v;
  logic                  accept;
  logic                  neg;

  generate
    if (VALUE_BITS > IN_VALUE_W) begin : g_ext
      assign v = {{(VALUE_BITS-IN_VALUE_W){1'b0}}, in_data.value};
    end else begin : g_trunc
      assign v = in_data.value[VALUE_BITS-1:0];
    end
  endgenerate

  assign in_stall = front_valid_r && !q_status.ready;
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid_r && q_status.ready;
  assign neg      = (in_data.func == MODE_SDEC) && v[VALUE_BITS-1];

  always_comb begin
    front_valid_nxt = front_valid_r;
    ctl_nxt         = ctl_r;
    mag_nxt         = mag_r;
    if (push) begin
      front_valid_nxt = 1'b0;
    end
    // the unused mode is dropped here and produces no text
    if (accept && (in_data.func == MODE_SDEC || in_data.func == MODE_UDEC ||
                   in_data.func == MODE_HEX)) begin
      front_valid_nxt = 1'b1;
      ctl_nxt.hex     = (in_data.func == MODE_HEX);
      ctl_nxt.neg     = neg;
      mag_nxt         = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    ctl_r <= ctl_nxt;
    mag_r <= mag_nxt;
  end

  assign job_ctl = ctl_r;
  assign job_mag = mag_r;

endmodule

// File: sv/i2a_queue.sv
// two-entry job queue between the front and the back
module i2a_queue #(
  parameter int W = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       push_data,
  input  logic               pop,
  output logic [W-1:0]       pop_data,
  output i2a_pkg::q_status_t status
);
  import i2a_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign status.ready = (count_r != CW'(QUEUE_DEPTH));
  assign status.valid = (count_r != '0);
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/i2a_back.sv
// back stage: shift-add-3 conversion and character sequencer with output register
module i2a_back #(
  parameter int HEX_DIGITS = i2a_pkg::HEX_DIGITS_DEF,
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  pop,
  input  i2a_pkg::job_ctl_t     job_ctl,
  input  logic [VALUE_BITS-1:0] job_mag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2a_pkg::out_word_t    out_data
);
  import i2a_pkg::*;

  localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int DW         = DEC_DIGITS * 4;
  localparam int HW         = HEX_DIGITS * 4;
  localparam int CNT_MAX    = (VALUE_BITS > HEX_DIGITS) ? VALUE_BITS : HEX_DIGITS;
  localparam int CW         = $clog2(CNT_MAX);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_SIGN = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_PFX0 = 7'b0010000,
    S_PFXX = 7'b0100000,
    S_HEX  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [DW-1:0]         bcd_r, bcd_nxt;
  logic [HW-1:0]         hex_r, hex_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;
  logic [DW-1:0]         bcd_adj;
  logic [HW-1:0]         hex_load;
  logic [3:0]            dec_top;
  logic                  can_emit;

  generate
    if (HW > VALUE_BITS) begin : g_hext
      assign hex_load = {{(HW-VALUE_BITS){1'b0}}, job_mag};
    end else begin : g_htrunc
      assign hex_load = job_mag[HW-1:0];
    end
  endgenerate

  // add 3 to every digit of five or more before the shift
  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dig = bcd_r[4*i +: 4];
      bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  assign dec_top  = bcd_r[DW-1 -: 4];
  assign can_emit = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    hex_nxt       = hex_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          neg_nxt = job_ctl.neg;
          if (job_ctl.hex) begin
            hex_nxt   = hex_load;
            cnt_nxt   = CW'(HEX_DIGITS - 1);
            state_nxt = S_PFX0;
          end else begin
            bin_nxt   = job_mag;
            bcd_nxt   = '0;
            cnt_nxt   = CW'(VALUE_BITS - 1);
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[DW-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          cnt_nxt     = CW'(DEC_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? S_SIGN : S_DEC;
        end
      end
      S_SIGN: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = CHAR_MINUS;
          out_data_nxt.last_char = 1'b0;
          state_nxt              = S_DEC;
        end
      end
      S_DEC: begin
        // leading zeros are skipped, the units digit always prints
        if (dec_top != 4'd0 || started_r || cnt_r == '0) begin
          if (can_emit) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.text_char = CHAR_ZERO + {4'd0, dec_top};
            out_data_nxt.last_char = (cnt_r == '0);
            started_nxt            = 1'b1;
            bcd_nxt                = {bcd_r[DW-5:0], 4'd0};
            cnt_nxt                = cnt_r - CW'(1);
            if (cnt_r == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          bcd_nxt = {bcd_r[DW-5:0], 4'd0};
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_PFX0: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = CHAR_ZERO;
          out_data_nxt.last_char = 1'b0;
          state_nxt              = S_PFXX;
        end
      end
      S_PFXX: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = CHAR_X;
          out_data_nxt.last_char = 1'b0;
          state_nxt              = S_HEX;
        end
      end
      S_HEX: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = hex_char(hex_r[HW-1 -: 4]);
          out_data_nxt.last_char = (cnt_r == '0);
          hex_nxt                = hex_r << 4;
          cnt_nxt                = cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    hex_r      <= hex_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/integer_to_ascii_formatter_top.sv
// top level of the integer to ascii formatter
//
//   port group  dir  payload                      handshake
//   in_         in   in_word_t  {func, value}     in_valid / in_stall
//   out_        out  out_word_t {text_char, last} out_valid / out_stall
//
// decimal: the job is taken, VALUE_BITS shift-add-3 steps run, then each of the
// DEC_DIGITS decimal digit positions is visited (leading zeros skipped without
// output), after a '-' for a negative value
// hex: '0', 'x', then HEX_DIGITS digits, one character per cycle unless stalled
// the back stage takes no new job until it is back in idle; the two-entry
// queue and the front register let three more words in meanwhile
// reset clears only control state; out_stall holds the back's emitting states
module integer_to_ascii_formatter_top #(
  parameter int HEX_DIGITS = i2a_pkg::HEX_DIGITS_DEF,
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2a_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2a_pkg::out_word_t out_data
);
  import i2a_pkg::*;

  localparam int QW = VALUE_BITS + 2;

  q_status_t             q_status;
  logic                  push;
  logic                  pop;
  job_ctl_t              f_ctl;
  logic [VALUE_BITS-1:0] f_mag;
  logic [QW-1:0]         q_data;
  job_ctl_t              b_ctl;
  logic [VALUE_BITS-1:0] b_mag;

  i2a_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .job_ctl  (f_ctl),
    .job_mag  (f_mag)
  );

  i2a_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_ctl, f_mag}),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  assign b_ctl = q_data[QW-1 -: 2];
  assign b_mag = q_data[VALUE_BITS-1:0];

  i2a_back #(
    .HEX_DIGITS(HEX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_status.valid),
    .pop       (pop),
    .job_ctl   (b_ctl),
    .job_mag   (b_mag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.valid)
    else $error("back took a job from an empty queue");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_status.ready)
    else $error("input stalled while the queue had room");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_status.ready)
    else $error("job pushed into a full queue");

  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && !q_status.valid)
    else $error("output or queue not empty after reset");

endmodule

// File: verif/tb_top.sv
// self-checking testbench of the integer to ascii formatter
`timescale 1ns / 1ps

module tb_top;
  import i2a_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam int RANDOM_WORDS = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 60;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    in_word_t word;
    bit       drain_first;
  } job_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  job_t      job_q[$];
  out_word_t text_q[$];
  int        words_taken = 0;
  int        words_total = 0;
  int        err_cnt = 0;
  logic      in_taken = 1'b0;
  int        burst_left = 4;
  int        gap_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        stall_pct = 0;
  int        rx_cycle = 0;

  integer_to_ascii_formatter_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // append the characters one word must produce
  task automatic format_text(input in_word_t w);
    logic [31:0] mag;
    logic [3:0]  nib;
    logic [7:0]  txt[$];
    logic [7:0]  digs[$];
    out_word_t   ow;
    mag = w.value;
    case (w.func)
      MODE_SDEC, MODE_UDEC: begin
        if (w.func == MODE_SDEC && mag[31]) begin
          txt.push_back(CHAR_MINUS);
          mag = ~mag + 32'd1;
        end
        do begin
          digs.push_front(CHAR_ZERO + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 0);
        foreach (digs[i]) txt.push_back(digs[i]);
      end
      MODE_HEX: begin
        txt.push_back(CHAR_ZERO);
        txt.push_back(CHAR_X);
        for (int i = 7; i >= 0; i--) begin
          nib = mag[4*i +: 4];
          txt.push_back(nib < 4'd10 ? CHAR_ZERO + 8'(nib) : CHAR_UPPER_A + 8'(nib - 4'd10));
        end
      end
      default: ;
    endcase
    foreach (txt[i]) begin
      ow.text_char = txt[i];
      ow.last_char = (i == txt.size() - 1);
      text_q.push_back(ow);
    end
  endtask

  task automatic add_word(input logic [1:0] func, input logic [31:0] value,
                          input bit drain_first = 1'b0);
    job_t j;
    j.word.func  = func;
    j.word.value = value;
    j.drain_first = drain_first;
    job_q.push_back(j);
    words_total++;
  endtask

  // sender: bursts and gaps, payload held while stalled
  always @(negedge clk) begin
    job_t j;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (job_q.size() == 0 || (job_q[0].drain_first && text_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      j = job_q.pop_front();
      in_data  <= j.word;
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // receiver: changing stall density, one long hold-off
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 50 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: check characters first, then predict from the accepted word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected char expected none actual %h last %b",
                 $time, out_data.text_char, out_data.last_char);
      end else begin
        want = text_q.pop_front();
        if (out_data.text_char !== want.text_char) begin
          err_cnt++;
          $display("%0t: text_char expected %h actual %h",
                   $time, want.text_char, out_data.text_char);
        end
        if (out_data.last_char !== want.last_char) begin
          err_cnt++;
          $display("%0t: last_char expected %b actual %b",
                   $time, want.last_char, out_data.last_char);
        end
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      format_text(in_data);
      words_taken++;
    end
  end

  initial begin
    logic [1:0]  f;
    logic [31:0] v;
    logic [31:0] p;
    add_word(MODE_SDEC, 32'd0);
    add_word(MODE_SDEC, 32'd1);
    add_word(MODE_SDEC, 32'hFFFF_FFFF);
    add_word(MODE_SDEC, 32'h8000_0000);
    add_word(MODE_SDEC, 32'h7FFF_FFFF);
    add_word(MODE_SDEC, 32'd9);
    add_word(MODE_SDEC, 32'd10);
    add_word(MODE_SDEC, -32'sd10);
    add_word(MODE_UDEC, 32'd0);
    add_word(MODE_UDEC, 32'hFFFF_FFFF);
    add_word(MODE_UDEC, 32'h8000_0000);
    add_word(MODE_UDEC, 32'd1234567890);
    add_word(MODE_UDEC, 32'd10);
    add_word(MODE_HEX, 32'd0);
    add_word(MODE_HEX, 32'hFFFF_FFFF);
    add_word(MODE_HEX, 32'hDEAD_BEEF);
    add_word(MODE_HEX, 32'h0123_ABCD);
    add_word(MODE_UNUSED, 32'd0);
    add_word(MODE_UNUSED, 32'hFFFF_FFFF);
    add_word(MODE_SDEC, 32'd42, 1'b1);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: f = MODE_SDEC;
        3, 4, 5: f = MODE_UDEC;
        6, 7, 8: f = MODE_HEX;
        default: f = MODE_UNUSED;
      endcase
      case ($urandom_range(0, 5))
        0, 5: v = $urandom;
        1: v = $urandom_range(0, 99);
        2: v = -$urandom_range(1, 99);
        3: begin
          p = 32'd1;
          repeat ($urandom_range(0, 9)) p = p * 32'd10;
          v = p + $urandom_range(0, 2) - 32'd1;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            default: v = 32'h8000_0001;
          endcase
        end
      endcase
      add_word(f, v, n == 100);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (words_taken == words_total);
    wait (text_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
